// ===== src/cscan_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// C-SCAN request ordering package
// Shared types and fixed constants of the request ordering unit.
// ----------------------------------------------------------------------------
package cscan_pkg;

	// Width of the head position register.
	localparam int HEAD_WIDTH = 16;

	typedef logic [HEAD_WIDTH-1:0] head_t;

endpackage
`default_nettype wire

// ===== src/cscan_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cscan_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== src/cscan_request_order_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Loading takes one request per cycle; busy stays low while a batch is collected.
// After the closing request, each result comes from one pass over the request RAM
// that reads every stored request, with registered read data.
// Results are single-cycle strobes; the receiver cannot stall them.
// Reset empties the batch, clears the drop flag and sets the head position to zero.
// ----------------------------------------------------------------------------
// C-SCAN request ordering unit
// Collects a batch of track requests in RAM and emits it in circular-scan
// order by repeated minimum-search passes over the stored requests.
// ----------------------------------------------------------------------------
module cscan_request_order_unit #(
	parameter int MAX_REQUESTS = 64,
	parameter int TRACK_WIDTH  = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire cscan_pkg::head_t       cfg_wdata,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic [TRACK_WIDTH-1:0] track,
	input  wire logic                   batch_end,
	output logic                        result_valid,
	output logic [TRACK_WIDTH-1:0]      served_track,
	output logic                        final_res,
	output logic                        overflowed
);

	import cscan_pkg::*;

	localparam int IW   = $clog2(MAX_REQUESTS);
	localparam int CW   = $clog2(MAX_REQUESTS + 1);
	localparam int CMPW = (TRACK_WIDTH > HEAD_WIDTH) ? TRACK_WIDTH : HEAD_WIDTH;
	localparam int KW   = 1 + TRACK_WIDTH + IW;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_REQUESTS);

	typedef enum logic {
		S_LOAD,
		S_SCAN
	} state_t;

	state_t                 state_q;
	head_t                  head_q;
	logic [CW-1:0]          count_q;
	logic                   dropped_q;
	logic [CW-1:0]          rd_cnt_q;
	logic [CW-1:0]          emitted_q;
	logic                   v_s1;
	logic [IW-1:0]          idx_s1;
	logic                   best_valid_q;
	logic [KW-1:0]          best_key_q;
	logic                   have_last_q;
	logic [KW-1:0]          last_key_q;
	logic                   result_valid_q;
	logic [TRACK_WIDTH-1:0] served_q;
	logic                   final_q;
	logic                   overflow_q;

	logic                   accept;
	logic                   has_room;
	logic                   ram_we;
	logic                   issue;
	logic [TRACK_WIDTH-1:0] rd_data;
	logic                   cand_low;
	logic [KW-1:0]          cand_key;
	logic                   take;
	logic [KW-1:0]          best_next;
	logic                   pass_end;
	logic                   is_final;

	assign busy     = (state_q != S_LOAD);
	assign accept   = start && !busy;
	assign has_room = (count_q < MAX_CNT);
	assign ram_we   = accept && has_room;
	assign issue    = (state_q == S_SCAN) && (rd_cnt_q < count_q);

	cscan_ram #(
		.WIDTH(TRACK_WIDTH),
		.DEPTH(MAX_REQUESTS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[IW-1:0]),
		.wdata(track),
		.re   (issue),
		.raddr(rd_cnt_q[IW-1:0]),
		.rdata(rd_data)
	);

	// Sort key: tracks below the head go after the wrap, ties break by slot.
	assign cand_low = (CMPW'(rd_data) < CMPW'(head_q));
	assign cand_key = {cand_low, rd_data, idx_s1};

	always_comb begin
		take = v_s1 && (!have_last_q || (cand_key > last_key_q))
			&& (!best_valid_q || (cand_key < best_key_q));
		best_next = take ? cand_key : best_key_q;
	end

	assign pass_end = v_s1 && (CW'(idx_s1) == (count_q - CW'(1)));
	assign is_final = ((emitted_q + CW'(1)) == count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_LOAD;
			head_q         <= '0;
			count_q        <= '0;
			dropped_q      <= 1'b0;
			rd_cnt_q       <= '0;
			emitted_q      <= '0;
			v_s1           <= 1'b0;
			idx_s1         <= '0;
			best_valid_q   <= 1'b0;
			best_key_q     <= '0;
			have_last_q    <= 1'b0;
			last_key_q     <= '0;
			result_valid_q <= 1'b0;
			served_q       <= '0;
			final_q        <= 1'b0;
			overflow_q     <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			if (cfg_we) begin
				head_q <= cfg_wdata;
			end
			case (state_q)
				S_LOAD: begin
					v_s1 <= 1'b0;
					if (accept) begin
						if (has_room) begin
							count_q <= count_q + CW'(1);
						end else begin
							dropped_q <= 1'b1;
						end
						if (batch_end) begin
							state_q      <= S_SCAN;
							rd_cnt_q     <= '0;
							emitted_q    <= '0;
							best_valid_q <= 1'b0;
							have_last_q  <= 1'b0;
						end
					end
				end
				S_SCAN: begin
					v_s1   <= issue;
					idx_s1 <= rd_cnt_q[IW-1:0];
					if (issue) begin
						rd_cnt_q <= rd_cnt_q + CW'(1);
					end
					if (take) begin
						best_key_q   <= cand_key;
						best_valid_q <= 1'b1;
					end
					if (pass_end) begin
						// The pass has seen every entry: the minimum above the
						// previous pick is the next request in service order.
						result_valid_q <= 1'b1;
						served_q       <= best_next[IW +: TRACK_WIDTH];
						final_q        <= is_final;
						overflow_q     <= is_final && dropped_q;
						last_key_q     <= best_next;
						have_last_q    <= 1'b1;
						best_valid_q   <= 1'b0;
						rd_cnt_q       <= '0;
						if (is_final) begin
							state_q   <= S_LOAD;
							count_q   <= '0;
							dropped_q <= 1'b0;
						end else begin
							emitted_q <= emitted_q + CW'(1);
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign served_track = served_q;
	assign final_res    = final_q;
	assign overflowed   = overflow_q;

	a_final_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && final_res) |-> !busy)
		else $error("final request emitted while unit still busy");

	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("two requests emitted in consecutive cycles");

	a_ovf_final: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && overflowed) |-> final_res)
		else $error("overflow flag on a non-final request");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT)
		else $error("request count beyond capacity");

endmodule
`default_nettype wire
